### design/barometric_compensation_core_assert.svh
// Assertion macros used by the checker file.
`ifndef BAROMETRIC_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_COMPENSATION_CORE_ASSERT_SVH

// Implication checked while out of reset.
`define BCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked during and after reset.
`define BCC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/bcc_pkg.sv
package bcc_pkg;

    // One input item
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in;

    // One result item
    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_error;
    } t_out;

    // Calibration register file
    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0]  oss;
    } t_cal;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } t_reg_idx;

    localparam logic [1:0]  OSS_RESET   = 2'd3;
    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] C_SQ_GAIN   = 32'd3038;
    localparam logic [31:0] C_LIN_GAIN  = 32'd7357;
    localparam logic [31:0] C_OFFSET    = 32'd3791;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] B4_BIAS     = 32'd32768;
    localparam int          QUEUE_DEPTH = 2;

endpackage

### design/bcc_front.sv
module bcc_front
    import bcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_q_valid,
    output t_in  o_q_data,
    input  logic i_q_pop
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_in             r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_stall   = (r_cnt == CntW'(QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_data  = r_mem[r_rd];

    // Hold pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store an incoming transfer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### design/bcc_div.sv
module bcc_div
    import bcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        q_bit;

    // One restoring step a cycle
    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign q_bit  = !diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_cnt  <= 5'd31;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= q_bit ? diff[31:0] : rem_sh[31:0];
                r_quo <= {r_quo[30:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### design/bcc_back.sv
module bcc_back
    import bcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cal i_cal,
    input  logic i_q_valid,
    input  t_in  i_q_data,
    output logic o_q_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_T1, ST_TDIV, ST_T3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
        ST_PDIV, ST_C1, ST_C2, ST_C3, ST_C4, ST_DONE
    } t_state;

    t_state      r_state;
    logic [18:0] r_up;
    logic [31:0] r_prod;
    logic [31:0] r_x1;
    logic [31:0] r_x2;
    logic [31:0] r_b5;
    logic [31:0] r_b6;
    logic [31:0] r_sq;
    logic [31:0] r_b3;
    logic [31:0] r_tmp;
    logic [31:0] r_b4;
    logic [31:0] r_p;
    logic        r_err;
    logic        r_neg;
    logic        r_dbl;
    t_out        r_out;
    logic        r_out_valid;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] mul_a, mul_b;
    logic [31:0] mul_full;
    logic [31:0] den, num, num_abs, den_abs;
    logic [31:0] x1_t, x3_s, b3_pre, b3_sh, x3_p, b7;
    logic [31:0] c_x2, c_sum, t_wide, q_signed;
    logic [15:0] t_sat;
    logic        out_free;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    // Unpack calibration words
    assign ac1 = {{16{i_cal.ac1_ac2[31]}}, i_cal.ac1_ac2[31:16]};
    assign ac2 = {{16{i_cal.ac1_ac2[15]}}, i_cal.ac1_ac2[15:0]};
    assign ac3 = {{16{i_cal.ac3_ac4[31]}}, i_cal.ac3_ac4[31:16]};
    assign ac4 = {16'd0, i_cal.ac3_ac4[15:0]};
    assign ac5 = {16'd0, i_cal.ac5_ac6[31:16]};
    assign ac6 = {16'd0, i_cal.ac5_ac6[15:0]};
    assign b1  = {{16{i_cal.b1_b2[31]}}, i_cal.b1_b2[31:16]};
    assign b2  = {{16{i_cal.b1_b2[15]}}, i_cal.b1_b2[15:0]};
    assign mc  = {{16{i_cal.mc_md[31]}}, i_cal.mc_md[31:16]};
    assign md  = {{16{i_cal.mc_md[15]}}, i_cal.mc_md[15:0]};

    // Temperature divide operands
    assign x1_t    = $signed(r_prod) >>> 15;
    assign den     = x1_t + md;
    assign num     = mc << 11;
    assign num_abs = num[31] ? (32'd0 - num) : num;
    assign den_abs = den[31] ? (32'd0 - den) : den;
    assign q_signed = r_neg ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;

    // b3 from x3 and the oversampling shift
    assign x3_s   = $unsigned($signed(r_prod) >>> 11) + r_x2;
    assign b3_pre = (ac1 << 2) + x3_s;
    assign b3_sh  = b3_pre << i_cal.oss;
    assign x3_p   = $signed(r_x1 + $unsigned($signed(r_prod) >>> 16) + 32'd2) >>> 2;
    assign b7     = r_prod;

    // Final pressure correction
    assign c_x2  = $signed(32'd0 - r_prod) >>> 16;
    assign c_sum = $signed(r_x1 + c_x2 + C_OFFSET) >>> 4;

    // Saturate temperature to 16 bits
    assign t_wide = $signed(r_b5 + 32'd8) >>> 4;
    always_comb begin
        if ($signed(t_wide) > 32'sd32767) begin
            t_sat = 16'h7fff;
        end else if ($signed(t_wide) < -32'sd32768) begin
            t_sat = 16'h8000;
        end else begin
            t_sat = t_wide[15:0];
        end
    end

    // Select multiplier operands per step
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                mul_a = {16'd0, i_q_data.raw_temperature} - ac6;
                mul_b = ac5;
            end
            ST_P0:   begin mul_a = r_b6;   mul_b = r_b6;  end
            ST_P1:   begin mul_a = ac2;    mul_b = r_b6;  end
            ST_P2:   begin mul_a = b2;     mul_b = r_sq;  end
            ST_P3:   begin mul_a = ac3;    mul_b = r_b6;  end
            ST_P4:   begin mul_a = b1;     mul_b = r_sq;  end
            ST_P6:   begin mul_a = ac4;    mul_b = r_tmp; end
            ST_P7: begin
                mul_a = {13'd0, r_up} - r_b3;
                mul_b = B7_SCALE >> i_cal.oss;
            end
            ST_C1: begin
                mul_a = $signed(r_p) >>> 8;
                mul_b = $signed(r_p) >>> 8;
            end
            ST_C2:   begin mul_a = r_prod; mul_b = C_SQ_GAIN;  end
            ST_C3:   begin mul_a = r_p;    mul_b = C_LIN_GAIN; end
            default: begin mul_a = '0;     mul_b = '0;         end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    // Start the shared divider
    always_comb begin
        div_req = '0;
        if (r_state == ST_T1 && den != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = num_abs;
            div_req.divisor  = den_abs;
        end else if (r_state == ST_P8 && r_b4 != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = b7[31] ? b7 : (b7 << 1);
            div_req.divisor  = r_b4;
        end
    end

    bcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || !i_stall;

    // Sequence one item through the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= mul_full;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_up    <= i_q_data.raw_pressure;
                        r_err   <= 1'b0;
                        r_state <= ST_T1;
                    end
                end
                ST_T1: begin
                    r_x1  <= x1_t;
                    r_neg <= num[31] ^ den[31];
                    if (den == '0) begin
                        r_err   <= 1'b1;
                        r_x2    <= '0;
                        r_state <= ST_T3;
                    end else begin
                        r_state <= ST_TDIV;
                    end
                end
                ST_TDIV: begin
                    if (div_rsp.done) begin
                        r_x2    <= q_signed;
                        r_state <= ST_T3;
                    end
                end
                ST_T3: begin
                    r_b5    <= r_x1 + r_x2;
                    r_b6    <= r_x1 + r_x2 - B6_OFFSET;
                    r_state <= ST_P0;
                end
                ST_P0: r_state <= ST_P1;
                ST_P1: begin
                    r_sq    <= $signed(r_prod) >>> 12;
                    r_state <= ST_P2;
                end
                ST_P2: begin
                    r_x2    <= $signed(r_prod) >>> 11;
                    r_state <= ST_P3;
                end
                ST_P3: begin
                    r_b3    <= $signed(b3_sh + 32'd2) >>> 2;
                    r_state <= ST_P4;
                end
                ST_P4: begin
                    r_x1    <= $signed(r_prod) >>> 13;
                    r_state <= ST_P5;
                end
                ST_P5: begin
                    r_tmp   <= x3_p + B4_BIAS;
                    r_state <= ST_P6;
                end
                ST_P6: r_state <= ST_P7;
                ST_P7: begin
                    r_b4    <= r_prod >> 15;
                    r_state <= ST_P8;
                end
                ST_P8: begin
                    r_dbl <= b7[31];
                    if (r_b4 == '0) begin
                        r_err   <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_PDIV;
                    end
                end
                ST_PDIV: begin
                    if (div_rsp.done) begin
                        r_p     <= r_dbl ? (div_rsp.quotient << 1) : div_rsp.quotient;
                        r_state <= ST_C1;
                    end
                end
                ST_C1: r_state <= ST_C2;
                ST_C2: r_state <= ST_C3;
                ST_C3: begin
                    r_x1    <= $signed(r_prod) >>> 16;
                    r_state <= ST_C4;
                end
                ST_C4: begin
                    r_p     <= r_p + c_sum;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out.temperature_tenths <= t_sat;
                        r_out.pressure_pa        <= r_err ? 32'd0 : r_p;
                        r_out.divide_error       <= r_err;
                        r_state                  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### design/barometric_compensation_core.sv
// Barometric compensation core.
// Input channel: i_valid / o_stall carry one raw temperature and raw pressure
// word per transfer on i_data. Output channel: o_valid / i_stall carry the
// compensated temperature (0.1 degC, saturated), pressure in Pa and a divide
// error flag on o_data. Calibration words and the oversampling mode are
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the core is idle; the core itself never checks this.
// A two-entry input queue takes transfers while the back end computes, so a
// new item may follow in the next cycle until the queue fills. Each item
// runs two 32-step divides on the single shared restoring divider; a zero
// divisor skips its divide. One 32x32 multiplier is reused across the steps.
// The back end takes a new item only once the last has left the sequencer.
// Reset clears the queue, the output register and the sequencer, and loads
// the calibration words with zero and the oversampling mode with 3.
// When the receiver stalls, the result stays on o_data; the back end then
// holds the next finished result and the queue fills before o_stall rises.
module barometric_compensation_core
    import bcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cal r_cal;
    logic q_valid;
    t_in  q_data;
    logic q_pop;

    // Write calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '{ac1_ac2: '0, ac3_ac4: '0, ac5_ac6: '0, b1_b2: '0, mc_md: '0,
                       oss: OSS_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AC1_AC2: r_cal.ac1_ac2 <= i_cfg_data;
                REG_AC3_AC4: r_cal.ac3_ac4 <= i_cfg_data;
                REG_AC5_AC6: r_cal.ac5_ac6 <= i_cfg_data;
                REG_B1_B2:   r_cal.b1_b2   <= i_cfg_data;
                REG_MC_MD:   r_cal.mc_md   <= i_cfg_data;
                REG_OSS:     r_cal.oss     <= i_cfg_data[1:0];
                default:     r_cal         <= r_cal;
            endcase
        end
    end

    bcc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    bcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cal     (r_cal),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

### design/bcc_checker.sv
`include "barometric_compensation_core_assert.svh"

module bcc_checker
    import bcc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // Output handshake holds under stall
    `BCC_ASSERT_IMPL(a_valid_hold, i_clk, i_rst_n, o_valid && i_stall, ##1 o_valid)
    `BCC_ASSERT_IMPL(a_data_hold, i_clk, i_rst_n, o_valid && i_stall, ##1 $stable(o_data))

    // Reset empties the queue and the output register
    `BCC_ASSERT_NEXT(a_rst_out, i_clk, !i_rst_n, !o_valid)
    `BCC_ASSERT_NEXT(a_rst_queue, i_clk, !i_rst_n, !o_stall)

    // A divide error forces zero pressure
    `BCC_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_data.divide_error,
                     o_data.pressure_pa == 32'sd0)

endmodule

bind barometric_compensation_core bcc_checker u_bcc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

### tb/tb_barometric_compensation_core.sv
module tb_barometric_compensation_core;
    import bcc_pkg::*;

    // Expected-result store and checker for compensated readings
    class baro_scoreboard;
        t_out pending_q[$];
        int   mismatch_cnt;
        int   reading_cnt;

        function void note_sample(t_out exp_val);
            pending_q.push_back(exp_val);
        endfunction

        function void check_reading(t_out act);
            t_out exp_val;
            reading_cnt++;
            if (pending_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected reading t=%0d p=%0d err=%0b",
                             act.temperature_tenths, act.pressure_pa, act.divide_error);
                return;
            end
            exp_val = pending_q.pop_front();
            if (act.temperature_tenths !== exp_val.temperature_tenths ||
                act.pressure_pa !== exp_val.pressure_pa ||
                act.divide_error !== exp_val.divide_error) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: exp t=%0d p=%0d err=%0b, got t=%0d p=%0d err=%0b",
                             exp_val.temperature_tenths, exp_val.pressure_pa,
                             exp_val.divide_error, act.temperature_tenths,
                             act.pressure_pa, act.divide_error);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    barometric_compensation_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    baro_scoreboard sb = new();

    // Model copy of the calibration registers
    logic [31:0] cal_word [0:4];
    logic [1:0]  cal_oss;

    int  idle_pct = 21;
    int  sample_cnt = 0;
    int  err_cnt = 0;

    function automatic logic [31:0] sxt16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] shr_s(logic [31:0] v, int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    // Compensate one raw sample with the current calibration
    function automatic t_out compensate(t_in s);
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, den, sq, tq;
        int   oss;
        bit   div_err;
        t_out r;
        div_err = 1'b0;
        ut = {16'd0, s.raw_temperature};
        up = {13'd0, s.raw_pressure};
        oss = cal_oss;
        ac1 = sxt16(cal_word[REG_AC1_AC2][31:16]);
        ac2 = sxt16(cal_word[REG_AC1_AC2][15:0]);
        ac3 = sxt16(cal_word[REG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal_word[REG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal_word[REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_word[REG_AC5_AC6][15:0]};
        b1 = sxt16(cal_word[REG_B1_B2][31:16]);
        b2 = sxt16(cal_word[REG_B1_B2][15:0]);
        mc = sxt16(cal_word[REG_MC_MD][31:16]);
        md = sxt16(cal_word[REG_MC_MD][15:0]);

        // temperature
        x1 = shr_s((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) begin
            div_err = 1'b1;
            x2 = 0;
        end else if (mc << 11 == 32'h8000_0000 && den == 32'hFFFF_FFFF) begin
            x2 = 32'h8000_0000;
        end else begin
            x2 = $unsigned($signed(mc << 11) / $signed(den));
        end
        b5 = x1 + x2;
        tq = shr_s(b5 + 32'd8, 4);
        if ($signed(tq) > 32767) r.temperature_tenths = 16'sh7FFF;
        else if ($signed(tq) < -32768) r.temperature_tenths = 16'sh8000;
        else r.temperature_tenths = tq[15:0];

        // pressure
        b6 = b5 - B6_OFFSET;
        sq = shr_s(b6 * b6, 12);
        x1 = shr_s(b2 * sq, 11);
        x2 = shr_s(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr_s(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = shr_s(ac3 * b6, 13);
        x2 = shr_s(b1 * sq, 16);
        x3 = shr_s(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
        b7 = (up - b3) * (B7_SCALE >> oss);
        if (b4 == 0) begin
            div_err = 1'b1;
            p = 0;
        end else begin
            p = !b7[31] ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
            x1 = shr_s(p, 8);
            x1 = x1 * x1;
            x1 = shr_s(x1 * C_SQ_GAIN, 16);
            x2 = shr_s(32'd0 - C_LIN_GAIN * p, 16);
            p = p + shr_s(x1 + x2 + C_OFFSET, 4);
        end
        if (div_err) p = 0;
        r.pressure_pa = p;
        r.divide_error = div_err;
        return r;
    endfunction

    // Write one calibration register while idle
    task automatic write_cal(t_reg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_OSS) cal_oss = val[1:0];
        else cal_word[idx] = val;
        @(posedge i_clk);
    endtask

    // Send one sample, with random idle cycles ahead of it
    task automatic send_sample(logic [15:0] ut, logic [18:0] up);
        t_in s;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        s.raw_temperature = ut;
        s.raw_pressure = up;
        i_valid <= 1'b1;
        i_data <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(compensate(s));
        if (sb.pending_q[$].divide_error) err_cnt++;
        sample_cnt++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Typical datasheet calibration set
    task automatic load_typical(logic [1:0] oss);
        write_cal(REG_AC1_AC2, {16'd408, -16'sd72});
        write_cal(REG_AC3_AC4, {-16'sd14383, 16'd32741});
        write_cal(REG_AC5_AC6, {16'd32757, 16'd23153});
        write_cal(REG_B1_B2, {16'd6190, 16'd4});
        write_cal(REG_MC_MD, {-16'sd8711, 16'd2868});
        write_cal(REG_OSS, {30'd0, oss});
    endtask

    // Random result stall on the receive side
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < idle_pct);
        if (i_rst_n && o_valid && !i_stall) sb.check_reading(o_data);
    end

    initial begin
        cal_word[0] = 0; cal_word[1] = 0; cal_word[2] = 0;
        cal_word[3] = 0; cal_word[4] = 0;
        cal_oss = OSS_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All-zero calibration: both divisors zero
        send_sample(16'h0000, 19'h00000);
        send_sample(16'hFFFF, 19'h7FFFF);
        drain();

        // Typical calibration, extremes of the raw words at every oss
        for (int m = 0; m < 4; m++) begin
            load_typical(m[1:0]);
            send_sample(16'd27898, 19'd23843 << m);
            send_sample(16'h0000, 19'h00000);
            send_sample(16'hFFFF, 19'h7FFFF);
            send_sample(16'h8000, 19'h40000);
            drain();
        end

        // Zero temperature divisor only: mc chosen, ac5 zero makes x1 zero, md zero
        load_typical(2'd0);
        write_cal(REG_AC5_AC6, {16'd0, 16'd0});
        write_cal(REG_MC_MD, {16'h1234, 16'd0});
        send_sample(16'd1000, 19'd30000);
        drain();
        // Zero pressure divisor only: ac4 zero
        load_typical(2'd1);
        write_cal(REG_AC3_AC4, {-16'sd14383, 16'd0});
        send_sample(16'd27898, 19'd47000);
        drain();
        // Extreme coefficients, forces overflow
        write_cal(REG_AC1_AC2, 32'h8000_7FFF);
        write_cal(REG_AC3_AC4, 32'h7FFF_FFFF);
        write_cal(REG_AC5_AC6, 32'hFFFF_0000);
        write_cal(REG_B1_B2, 32'h8000_8000);
        write_cal(REG_MC_MD, 32'h7FFF_7FFF);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'h0000, 19'h00000);
        drain();

        // Random phases: typical-ish calibrations, then fully random ones
        for (int ph = 0; ph < 7; ph++) begin
            idle_pct = (ph == 3) ? 0 : 21;
            if (ph < 3) begin
                load_typical(2'($urandom_range(3)));
                write_cal(REG_AC5_AC6, {16'($urandom_range(20000, 40000)),
                                        16'($urandom_range(15000, 30000))});
            end else begin
                write_cal(REG_AC1_AC2, $urandom);
                write_cal(REG_AC3_AC4, $urandom);
                write_cal(REG_AC5_AC6, $urandom);
                write_cal(REG_B1_B2, $urandom);
                write_cal(REG_MC_MD, $urandom);
                write_cal(REG_OSS, 32'($urandom_range(3)));
            end
            for (int k = 0; k < 100; k++)
                send_sample(16'($urandom), 19'($urandom));
            drain();
        end
        idle_pct = 21;

        $display("Sent %0d samples over several calibration sets and all oversampling modes,",
                 sample_cnt);
        $display("%0d of them with a zero divisor; %0d readings checked.", err_cnt,
                 sb.reading_cnt);
        if (sb.mismatch_cnt == 0 && sb.pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
